// ===== hdl/fsd_pkg.sv =====
// shared types and constants for the stream deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int SEQ_W    = 16;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 32;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h2A;
    localparam logic [BYTE_W-1:0] KIND_MIN   = 8'd1;
    localparam logic [BYTE_W-1:0] KIND_MAX   = 8'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PAYLOAD = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STRAY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   frame_kind;
        logic [SEQ_W-1:0]    frame_seq;
        logic [BYTE_W-1:0]   payload_byte;
        logic                last;
    } result_t;

endpackage

// ===== hdl/fsd_in_stage.sv =====
// input register stage: holds one received byte until the parser takes it
// depends on fsd_pkg
`timescale 1ns / 1ps

module fsd_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [fsd_pkg::BYTE_W-1:0] s_data,
    output logic                      byte_valid,
    output logic [fsd_pkg::BYTE_W-1:0] byte_data,
    input  logic                      take
);
    import fsd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    // stage can refill in the same cycle it is drained
    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            data_reg <= s_data;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// ===== hdl/fsd_parser.sv =====
// frame parser: header state machine, payload count and result decision
// depends on fsd_pkg
`timescale 1ns / 1ps

module fsd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [fsd_pkg::BYTE_W-1:0] rx_byte,
    output logic                       has_result,
    output fsd_pkg::result_t           result
);
    import fsd_pkg::*;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_SEQ_HI  = 3'd2;
    localparam logic [2:0] PH_SEQ_LO  = 3'd3;
    localparam logic [2:0] PH_LEN_HI  = 3'd4;
    localparam logic [2:0] PH_LEN_LO  = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    logic [2:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] kind_reg, kind_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [LEN_W-1:0]  frame_len;
    logic              kind_known;
    logic              final_byte;

    assign kind_known = (kind_reg >= KIND_MIN) && (kind_reg <= KIND_MAX);
    assign frame_len  = {left_reg[LEN_W-1:BYTE_W], rx_byte};
    // one or zero bytes left
    assign final_byte = (left_reg[LEN_W-1:1] == '0);

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        seq_next   = seq_reg;
        left_next  = left_reg;
        has_result = 1'b0;
        result     = '0;
        unique case (phase_reg)
            PH_TYPE:
            begin
                kind_next  = rx_byte;
                phase_next = PH_SEQ_HI;
            end
            PH_SEQ_HI:
            begin
                seq_next   = {rx_byte, {BYTE_W{1'b0}}};
                phase_next = PH_SEQ_LO;
            end
            PH_SEQ_LO:
            begin
                seq_next   = {seq_reg[SEQ_W-1:BYTE_W], rx_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                left_next  = {rx_byte, {BYTE_W{1'b0}}};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                left_next = frame_len;
                if (frame_len == '0)
                begin
                    phase_next        = PH_HUNT;
                    has_result        = 1'b1;
                    result.status     = kind_known ? ST_EMPTY : ST_UNKNOWN;
                    result.frame_kind = kind_reg;
                    result.frame_seq  = seq_reg;
                    result.last       = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                left_next = final_byte ? '0 : left_reg - LEN_W'(1);
                if (final_byte)
                begin
                    phase_next = PH_HUNT;
                end
                result.frame_kind = kind_reg;
                result.frame_seq  = seq_reg;
                result.last       = final_byte;
                if (kind_known)
                begin
                    has_result          = 1'b1;
                    result.status       = ST_PAYLOAD;
                    result.payload_byte = rx_byte;
                end
                else
                begin
                    // unknown type: swallow, one marker at the end
                    has_result    = final_byte;
                    result.status = ST_UNKNOWN;
                end
            end
            default:
            begin
                // hunting, unused codes act the same
                if (rx_byte == START_BYTE)
                begin
                    phase_next = PH_TYPE;
                end
                else
                begin
                    phase_next    = PH_HUNT;
                    has_result    = 1'b1;
                    result.status = ST_STRAY;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            kind_reg  <= '0;
            seq_reg   <= '0;
            left_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            seq_reg   <= seq_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== hdl/fsd_out_stage.sv =====
// result register: holds one result until the downstream side takes it
// depends on fsd_pkg
`timescale 1ns / 1ps

module fsd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fsd_pkg::result_t result,
    output logic             ready,
    output logic             m_valid,
    input  logic             m_ready,
    output fsd_pkg::result_t m_result
);
    import fsd_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign ready = !valid_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== hdl/flap_stream_deframer_top.sv =====
// channel   dir  width  contents
// s_axis    in   8      tdata: rx_byte
// m_axis    out  32+2+1 tdata: frame_kind, frame_seq, payload_byte; tuser: status; tlast: last
//
// one byte per clock sustained while m_axis keeps taking results: input register, parser, result register
// a byte accepted into the input register has its result, if any, loaded into the result register once the slot is free
// rst_n clears the parser to hunting and empties both registers
// a stall on m_axis holds the result; s_axis keeps taking while a slot is free
// depends on fsd_pkg, fsd_in_stage, fsd_parser, fsd_out_stage
`timescale 1ns / 1ps

module flap_stream_deframer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] frame_kind, [23:8] frame_seq, [31:24] payload_byte
    output logic [fsd_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                  m_axis_tuser,   // [1:0] status
    output logic                        m_axis_tlast
);
    import fsd_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              take;
    logic              out_ready;
    logic              has_result;
    result_t           result;
    result_t           m_result;

    // a transaction leaves the input register whenever the result slot can take it
    assign take = byte_valid && out_ready;

    fsd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .take       (take)
    );

    fsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .rx_byte    (byte_data),
        .has_result (has_result),
        .result     (result)
    );

    fsd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take && has_result),
        .result   (result),
        .ready    (out_ready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {m_result.payload_byte, m_result.frame_seq, m_result.frame_kind};
    assign m_axis_tuser = m_result.status;
    assign m_axis_tlast = m_result.last;

    // stray bytes carry no frame information
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_STRAY)) |-> ((m_axis_tdata == '0) && !m_axis_tlast))
        else $error("stray result carries frame fields");

    // only payload results carry a data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_PAYLOAD)) |-> (m_axis_tdata[31:24] == '0))
        else $error("non-payload result carries a data byte");

    // empty and unknown-type results always close a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser == ST_EMPTY) || (m_axis_tuser == ST_UNKNOWN)))
        |-> m_axis_tlast)
        else $error("frame-closing result without tlast");

    // a result offered in the slot must not vanish before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("stalled result dropped");

endmodule

// ===== dv/tb_flap_stream_deframer_top.sv =====
// self-checking testbench for flap_stream_deframer_top: byte stream in, tagged results out
// predicts every result from the accepted bytes and checks them in order
// depends on fsd_pkg and the deframer rtl
`timescale 1ns / 1ps

module tb_flap_stream_deframer_top;

    import fsd_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 4;

    typedef enum logic [2:0] {
        P_HUNT    = 3'd0,
        P_KIND    = 3'd1,
        P_SEQ_HI  = 3'd2,
        P_SEQ_LO  = 3'd3,
        P_LEN_HI  = 3'd4,
        P_LEN_LO  = 3'd5,
        P_PAYLOAD = 3'd6
    } parse_phase_t;

    class frame_result_board;
        result_t      want_results[$];
        parse_phase_t phase;
        logic [7:0]   kind;
        logic [15:0]  seq;
        logic [15:0]  left;
        int           errors;

        function new();
            phase  = P_HUNT;
            kind   = '0;
            seq    = '0;
            left   = '0;
            errors = 0;
        endfunction

        function int pending();
            return want_results.size();
        endfunction

        // advance the parser copy by one accepted byte, queue any result it yields
        function void take_byte(logic [7:0] b);
            result_t r;
            bit      has;
            bit      fin;
            bit      known;
            r     = '0;
            has   = 1'b0;
            known = (kind >= KIND_MIN) && (kind <= KIND_MAX);
            case (phase)
                P_KIND:
                begin
                    kind  = b;
                    phase = P_SEQ_HI;
                end
                P_SEQ_HI:
                begin
                    seq   = {b, 8'h00};
                    phase = P_SEQ_LO;
                end
                P_SEQ_LO:
                begin
                    seq   = seq | {8'h00, b};
                    phase = P_LEN_HI;
                end
                P_LEN_HI:
                begin
                    left  = {b, 8'h00};
                    phase = P_LEN_LO;
                end
                P_LEN_LO:
                begin
                    left = left | {8'h00, b};
                    if (left == 16'd0)
                    begin
                        phase        = P_HUNT;
                        has          = 1'b1;
                        r.status     = known ? ST_EMPTY : ST_UNKNOWN;
                        r.frame_kind = kind;
                        r.frame_seq  = seq;
                        r.last       = 1'b1;
                    end
                    else
                    begin
                        phase = P_PAYLOAD;
                    end
                end
                P_PAYLOAD:
                begin
                    fin  = (left <= 16'd1);
                    left = fin ? 16'd0 : left - 16'd1;
                    if (fin)
                        phase = P_HUNT;
                    if (known)
                    begin
                        has            = 1'b1;
                        r.status       = ST_PAYLOAD;
                        r.frame_kind   = kind;
                        r.frame_seq    = seq;
                        r.payload_byte = b;
                        r.last         = fin;
                    end
                    else if (fin)
                    begin
                        has          = 1'b1;
                        r.status     = ST_UNKNOWN;
                        r.frame_kind = kind;
                        r.frame_seq  = seq;
                        r.last       = 1'b1;
                    end
                end
                default:
                begin
                    if (b == START_BYTE)
                    begin
                        phase = P_KIND;
                    end
                    else
                    begin
                        phase    = P_HUNT;
                        has      = 1'b1;
                        r.status = ST_STRAY;
                    end
                end
            endcase
            if (has)
                want_results.push_back(r);
        endfunction

        function void field_diff(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void match_result(result_t got);
            result_t exp_r;
            if (want_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
                return;
            end
            exp_r = want_results.pop_front();
            field_diff("status", 16'(exp_r.status), 16'(got.status));
            field_diff("frame_kind", 16'(exp_r.frame_kind), 16'(got.frame_kind));
            field_diff("frame_seq", exp_r.frame_seq, got.frame_seq);
            field_diff("payload_byte", 16'(exp_r.payload_byte), 16'(got.payload_byte));
            field_diff("last", 16'(exp_r.last), 16'(got.last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    frame_result_board sb = new();

    int src_idle_pct  = 28;
    int sink_idle_pct = 60;
    int sent_bytes    = 0;
    int cycles        = 0;

    flap_stream_deframer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // both monitors sample at the edge, before any driver update lands
    always @(posedge clk)
    begin
        result_t got;
        got.status       = m_axis_tuser;
        got.frame_kind   = m_axis_tdata[7:0];
        got.frame_seq    = m_axis_tdata[23:8];
        got.payload_byte = m_axis_tdata[31:24];
        got.last         = m_axis_tlast;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.match_result(got);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_flap_stream_deframer_top: FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_header(input logic [7:0] kind, input logic [15:0] seq,
                               input logic [15:0] len);
        send_byte(START_BYTE);
        send_byte(kind);
        send_byte(seq[15:8]);
        send_byte(seq[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // hold the sender until the pipeline has fully drained
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          roll;
        int          n;
        logic [7:0]  kind;
        logic [15:0] len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray bytes at both extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty frame of known type, top sequence number
        send_header(8'd1, 16'hFFFF, 16'd0);
        // empty frame of unknown type with a start byte inside the header
        send_header(8'd0, 16'h2A00, 16'd0);
        // known type, start byte and 0xff as payload
        send_header(8'd5, 16'h0000, 16'd2);
        send_byte(START_BYTE);
        send_byte(8'hFF);
        // unknown type, one swallowed payload byte
        send_header(8'hFF, 16'h8001, 16'd1);
        send_byte(8'h00);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct  = 28;
                    sink_idle_pct = 60;
                end
                1:
                begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 28;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            while (sent_bytes < (ITEM_TARGET * (ph + 1)) / 3)
            begin
                roll = $urandom_range(99);
                if (roll < 15)
                begin
                    // line noise
                    n = $urandom_range(4, 1);
                    repeat (n) send_byte(8'($urandom_range(255)));
                end
                else if (roll < 25)
                begin
                    // header cut short, following bytes get absorbed into it
                    send_byte(START_BYTE);
                    n = $urandom_range(5, 1);
                    repeat (n) send_byte(8'($urandom_range(255)));
                end
                else
                begin
                    if ($urandom_range(99) < 85)
                        kind = 8'($urandom_range(5, 1));
                    else if ($urandom_range(1) == 1)
                        kind = 8'h00;
                    else
                        kind = 8'($urandom_range(255, 6));
                    if ($urandom_range(39) == 0)
                        len = 16'($urandom_range(300, 256));
                    else
                        len = 16'($urandom_range(12));
                    send_header(kind, 16'($urandom_range(65535)), len);
                    repeat (len) send_byte(8'($urandom_range(255)));
                end
            end
            drain_all();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_flap_stream_deframer_top: PASS");
        else
            $display("tb_flap_stream_deframer_top: FAIL");
        $finish;
    end

endmodule
